[src/r2h_pkg.sv]
// Shared constants and types for the RGB to HSV converter.
// No dependencies; every other file imports this package.
package r2h_pkg;

  localparam int unsigned CHANNEL_BITS_DEF = 8;
  localparam int unsigned HUE_BITS_DEF     = 16;

  // Which channel holds the maximum; picks the hue sector
  typedef logic [1:0] sector_t;

  localparam sector_t SECTOR_RED   = 2'd0;
  localparam sector_t SECTOR_GREEN = 2'd1;
  localparam sector_t SECTOR_BLUE  = 2'd2;

endpackage

[src/r2h_ifs.sv]
// Valid/ready channel interfaces for pixels in and HSV results out.
// Depends on r2h_pkg for default widths.
interface r2h_pixel_if import r2h_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface r2h_hsv_if import r2h_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int unsigned HUE_BITS     = HUE_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [HUE_BITS-1:0]     hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

[src/r2h_ctrl.sv]
// Valid bits and per-stage load enables for the converter pipeline.
// Depends on r2h_pkg only by convention; each stage fills whenever it is empty or draining.
module r2h_ctrl import r2h_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [DEPTH-1:0] ld,
  output logic [DEPTH-1:0] vld
);

  logic [DEPTH-1:0] open_slot;
  logic [DEPTH-1:0] feed;

  always_comb begin
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (k == DEPTH - 1) begin
        open_slot[k] = !vld[k] || out_ready;
      end else begin
        open_slot[k] = !vld[k] || open_slot[k+1];
      end
    end
  end

  assign feed = {vld[DEPTH-2:0], in_valid};
  assign ld   = open_slot & feed;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < DEPTH; k++) begin
        if (open_slot[k]) begin
          vld[k] <= feed[k];
        end
      end
    end
  end

  assign in_ready  = open_slot[0];
  assign out_valid = vld[DEPTH-1];

endmodule

[src/r2h_prep.sv]
// Front stages: max/min and sector pick, then spread, hue numerator and divider operands.
// Depends on r2h_pkg for the sector codes.
module r2h_prep import r2h_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic [1:0]              ld,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output logic [CHANNEL_BITS+2:0] hue_rem,
  output logic [CHANNEL_BITS+2:0] hue_div,
  output logic [CHANNEL_BITS-1:0] sat_hi,
  output logic [CHANNEL_BITS-1:0] sat_lo,
  output logic [CHANNEL_BITS-1:0] sat_div,
  output logic [CHANNEL_BITS-1:0] bright
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned HW = CHANNEL_BITS + 3;

  // first stage
  logic [CB-1:0] r, g, b, mx, mn;
  sector_t       sector;
  logic [CB-1:0] mx_c, mn_c;
  sector_t       sector_c;

  always_comb begin
    mx_c = red;
    mn_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c) mx_c = blue;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c) mn_c = blue;
    // red wins ties over green, green over blue
    if (mx_c == red) begin
      sector_c = SECTOR_RED;
    end else if (mx_c == green) begin
      sector_c = SECTOR_GREEN;
    end else begin
      sector_c = SECTOR_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      r      <= red;
      g      <= green;
      b      <= blue;
      mx     <= mx_c;
      mn     <= mn_c;
      sector <= sector_c;
    end
  end

  // second stage
  logic [CB-1:0]          delta;
  logic [HW-1:0]          de, d6;
  logic signed [HW:0]     n_c, n_adj;
  logic [2*CB-1:0]        spread_scaled;

  always_comb begin
    delta = mx - mn;
    de    = {3'b000, delta};
    d6    = (de << 2) + (de << 1);
    case (sector)
      SECTOR_RED: begin
        n_c = $signed({4'b0000, g}) - $signed({4'b0000, b});
      end
      SECTOR_GREEN: begin
        n_c = $signed({1'b0, de << 1}) + $signed({4'b0000, b}) - $signed({4'b0000, r});
      end
      default: begin
        n_c = $signed({1'b0, de << 2}) + $signed({4'b0000, r}) - $signed({4'b0000, g});
      end
    endcase
    // wrap a negative angle by one full turn
    n_adj = n_c[HW] ? (n_c + $signed({1'b0, d6})) : n_c;
    spread_scaled = {delta, {CB{1'b0}}} - {{CB{1'b0}}, delta};
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      hue_rem <= n_adj[HW-1:0];
      // a divisor of one turns gray and black into a zero quotient
      hue_div <= (delta == '0) ? HW'(1) : d6;
      sat_hi  <= spread_scaled[2*CB-1:CB];
      sat_lo  <= spread_scaled[CB-1:0];
      sat_div <= (mx == '0) ? CB'(1) : mx;
      bright  <= mx;
    end
  end

endmodule

[src/r2h_div.sv]
// Pipelined restoring divider, one quotient bit per stage, leading stages pass through.
// Depends on r2h_pkg by convention; expects the high dividend part below the divisor.
module r2h_div import r2h_pkg::*; #(
  parameter int unsigned STAGES = 16,
  parameter int unsigned QBITS  = 16,
  parameter int unsigned DBITS  = 11
) (
  input  logic              clk,
  input  logic [STAGES-1:0] ld,
  input  logic [DBITS-1:0]  rem_in,
  input  logic [QBITS-1:0]  lo_in,
  input  logic [DBITS-1:0]  div_in,
  output logic [QBITS-1:0]  quot
);

  localparam int unsigned SKIP = STAGES - QBITS;

  logic [DBITS-1:0] rem [STAGES];
  logic [QBITS-1:0] lo  [STAGES];
  logic [DBITS-1:0] dv  [STAGES];
  logic [QBITS-1:0] q   [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [DBITS-1:0] rem_src, rem_nx;
    logic [QBITS-1:0] lo_src, lo_nx, q_src, q_nx;
    logic [DBITS-1:0] dv_src;
    logic [DBITS:0]   trial, diff;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_src = rem_in;
      assign lo_src  = lo_in;
      assign dv_src  = div_in;
      assign q_src   = '0;
    end else begin : g_chain
      assign rem_src = rem[k-1];
      assign lo_src  = lo[k-1];
      assign dv_src  = dv[k-1];
      assign q_src   = q[k-1];
    end

    always_comb begin
      trial = {rem_src, lo_src[QBITS-1]};
      diff  = trial - {1'b0, dv_src};
      fits  = (trial >= {1'b0, dv_src});
      if (k >= SKIP) begin
        rem_nx = fits ? diff[DBITS-1:0] : trial[DBITS-1:0];
        lo_nx  = lo_src << 1;
        q_nx   = {q_src[QBITS-2:0], fits};
      end else begin
        rem_nx = rem_src;
        lo_nx  = lo_src;
        q_nx   = q_src;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        rem[k] <= rem_nx;
        lo[k]  <= lo_nx;
        dv[k]  <= dv_src;
        q[k]   <= q_nx;
      end
    end
  end

  assign quot = q[STAGES-1];

endmodule

[src/rgb_to_hsv_convert.sv]
// Top level of the RGB to HSV converter: control, front stages, two dividers.
// Depends on r2h_pkg, r2h_ifs, r2h_ctrl, r2h_prep and r2h_div.
//
// Converts one pixel per clock while color.ready lets results drain. Two front stages find
// max/min, the sector and the divider operands; then two restoring dividers, one quotient
// bit per stage, produce hue and saturation in lockstep, and the last divider stage is the
// output register. Every stage has its own valid bit and fills whenever it is empty or
// draining, so bubbles collapse and a new request is taken while a finished result waits.
module rgb_to_hsv_convert import r2h_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int unsigned HUE_BITS     = HUE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  r2h_pixel_if.sink   pixel,
  r2h_hsv_if.source   color
);

  localparam int unsigned NDIV  = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
  localparam int unsigned DEPTH = NDIV + 2;
  localparam int unsigned HW    = CHANNEL_BITS + 3;

  logic [DEPTH-1:0]        ld;
  logic [DEPTH-1:0]        vld;
  logic [HW-1:0]           hue_rem, hue_div;
  logic [CHANNEL_BITS-1:0] sat_hi, sat_lo, sat_div, bright;
  logic [CHANNEL_BITS-1:0] bright_d [NDIV];

  r2h_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel.valid),
    .in_ready (pixel.ready),
    .out_ready(color.ready),
    .out_valid(color.valid),
    .ld       (ld),
    .vld      (vld)
  );

  r2h_prep #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_prep (
    .clk    (clk),
    .ld     (ld[1:0]),
    .red    (pixel.red),
    .green  (pixel.green),
    .blue   (pixel.blue),
    .hue_rem(hue_rem),
    .hue_div(hue_div),
    .sat_hi (sat_hi),
    .sat_lo (sat_lo),
    .sat_div(sat_div),
    .bright (bright)
  );

  r2h_div #(
    .STAGES(NDIV),
    .QBITS (HUE_BITS),
    .DBITS (HW)
  ) u_hue_div (
    .clk   (clk),
    .ld    (ld[DEPTH-1:2]),
    .rem_in(hue_rem),
    .lo_in ('0),
    .div_in(hue_div),
    .quot  (color.hue)
  );

  r2h_div #(
    .STAGES(NDIV),
    .QBITS (CHANNEL_BITS),
    .DBITS (CHANNEL_BITS)
  ) u_sat_div (
    .clk   (clk),
    .ld    (ld[DEPTH-1:2]),
    .rem_in(sat_hi),
    .lo_in (sat_lo),
    .div_in(sat_div),
    .quot  (color.saturation)
  );

  // carry the maximum alongside the division stages
  for (genvar k = 0; k < NDIV; k++) begin : g_bright
    always_ff @(posedge clk) begin
      if (ld[k+2]) begin
        bright_d[k] <= (k == 0) ? bright : bright_d[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign color.brightness = bright_d[NDIV-1];

`ifndef SYNTHESIS
  // black pixel gives zero saturation
  a_black_sat : assert property (@(posedge clk) disable iff (rst)
    (color.valid && color.brightness == '0) |-> color.saturation == '0)
    else $error("nonzero saturation for a black pixel");

  // zero saturation only for gray, and gray has zero hue
  a_gray_hue : assert property (@(posedge clk) disable iff (rst)
    (color.valid && color.saturation == '0) |-> color.hue == '0)
    else $error("nonzero hue for a gray pixel");

  // input stalls only when every stage holds a request and the output is blocked
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> ((&vld) && !color.ready))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
